>>> sv/blpf_pkg.sv
package blpf_pkg;

	typedef enum logic [1:0] {
		CMD_PUT  = 2'd0,
		CMD_LINE = 2'd1,
		CMD_FILL = 2'd2,
		CMD_READ = 2'd3
	} command_t;

	typedef enum logic [2:0] {
		ST_SWEEP,
		ST_IDLE,
		ST_DRAW,
		ST_DRAIN,
		ST_READ
	} state_t;

	typedef struct packed {
		command_t    command;
		logic [7:0]  x0;
		logic [7:0]  y0;
		logic [7:0]  x1;
		logic [7:0]  y1;
		logic        color;
		logic [7:0]  fill_value;
		logic [8:0]  byte_index;
	} request_t;

	typedef struct packed {
		logic [7:0] read_data;
		logic       accepted;
	} result_t;

	typedef struct packed {
		logic       valid;
		logic       last;
		logic [7:0] x;
		logic [7:0] y;
	} pixel_t;

	localparam int COORD_W = 8;
	localparam int ERR_W = 10;
	localparam int PAGE_SHIFT = 3;

endpackage

>>> sv/bresenham_line_into_page_framebuffer_top.sv
// Page-organized monochrome framebuffer with a line engine. After reset the block clears its
// store, one byte per cycle, all pages * PANEL_COLUMNS bytes (512 at the defaults), with busy
// high. A transaction is taken when start is high and busy is low, and exactly one result
// follows, shown for a single cycle with done high; it must be captured then, since the block
// cannot be stalled. The store is one memory with one write and one read port, and every pixel
// is a read-modify-write through it at one pixel per cycle. Put pixel and line step through
// their pixels, max(|x1-x0|, |y1-y0|) + 1 for a line, in the draw state and then a drain
// state; fill sweeps every byte as after reset; read byte passes through the read state. A new
// transaction can start in the cycle that shows the previous result.
module bresenham_line_into_page_framebuffer_top #(
	parameter int PANEL_COLUMNS = 128,
	parameter int PANEL_ROWS = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  blpf_pkg::request_t   request,
	output logic                 busy,
	output logic                 done,
	output blpf_pkg::result_t    result
);

	localparam int PAGES = (PANEL_ROWS + 7) / 8;
	localparam int STORE_BYTES = PAGES * PANEL_COLUMNS;
	localparam int ADDR_W = $clog2(STORE_BYTES);
	localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(STORE_BYTES - 1);

	blpf_pkg::state_t   state_q, state_d;
	blpf_pkg::pixel_t   pix;

	logic [ADDR_W-1:0]  cnt_q;
	logic [7:0]         fill_q;
	logic               report_q;
	logic               color_q;
	logic               acc_q;
	logic               inrange_q;
	logic               done_q;
	blpf_pkg::result_t  result_q;

	logic               pv_s1;
	logic [ADDR_W-1:0]  addr_s1;
	logic [7:0]         mask_s1;

	logic               fwd_valid_q;
	logic [ADDR_W-1:0]  fwd_addr_q;
	logic [7:0]         fwd_data_q;

	logic               accept;
	logic               load;
	logic [7:0]         end_x;
	logic [7:0]         end_y;
	logic               pix_in_panel;
	logic [ADDR_W-1:0]  pix_addr;
	logic               start_in_panel;
	logic               read_in_range;
	logic [ADDR_W-1:0]  raddr;
	logic [7:0]         rdata;
	logic [7:0]         cur_byte;
	logic               we;
	logic [ADDR_W-1:0]  waddr;
	logic [7:0]         wdata;

	blpf_stepper u_stepper (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (load),
		.x0     (request.x0),
		.y0     (request.y0),
		.x1     (end_x),
		.y1     (end_y),
		.pix    (pix)
	);

	blpf_ram #(
		.DEPTH (STORE_BYTES)
	) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	always_comb begin
		busy = state_q != blpf_pkg::ST_IDLE;
		accept = start && !busy;
		load = accept && (request.command == blpf_pkg::CMD_PUT ||
			request.command == blpf_pkg::CMD_LINE);
		// A single pixel is a line whose end point is its start point.
		end_x = (request.command == blpf_pkg::CMD_PUT) ? request.x0 : request.x1;
		end_y = (request.command == blpf_pkg::CMD_PUT) ? request.y0 : request.y1;
		start_in_panel = (32'(request.x0) < PANEL_COLUMNS) && (32'(request.y0) < PANEL_ROWS);
		read_in_range = 32'(request.byte_index) < STORE_BYTES;
		pix_in_panel = (32'(pix.x) < PANEL_COLUMNS) && (32'(pix.y) < PANEL_ROWS);
		pix_addr = ADDR_W'(32'(pix.y[7:blpf_pkg::PAGE_SHIFT]) * PANEL_COLUMNS + 32'(pix.x));
		raddr = (state_q == blpf_pkg::ST_IDLE) ? ADDR_W'(request.byte_index) : pix_addr;

		cur_byte = (fwd_valid_q && fwd_addr_q == addr_s1) ? fwd_data_q : rdata;
		if (state_q == blpf_pkg::ST_SWEEP) begin
			we = 1'b1;
			waddr = cnt_q;
			wdata = fill_q;
		end else begin
			we = pv_s1;
			waddr = addr_s1;
			wdata = color_q ? (cur_byte | mask_s1) : (cur_byte & ~mask_s1);
		end

		state_d = state_q;
		case (state_q)
			blpf_pkg::ST_SWEEP: begin
				if (cnt_q == LAST_ADDR) begin
					state_d = blpf_pkg::ST_IDLE;
				end
			end
			blpf_pkg::ST_IDLE: begin
				if (accept) begin
					case (request.command)
						blpf_pkg::CMD_PUT, blpf_pkg::CMD_LINE: state_d = blpf_pkg::ST_DRAW;
						blpf_pkg::CMD_FILL: state_d = blpf_pkg::ST_SWEEP;
						blpf_pkg::CMD_READ: state_d = blpf_pkg::ST_READ;
						default: state_d = blpf_pkg::ST_IDLE;
					endcase
				end
			end
			blpf_pkg::ST_DRAW: begin
				if (pix.last) begin
					state_d = blpf_pkg::ST_DRAIN;
				end
			end
			blpf_pkg::ST_DRAIN: state_d = blpf_pkg::ST_IDLE;
			blpf_pkg::ST_READ: state_d = blpf_pkg::ST_IDLE;
			default: state_d = blpf_pkg::ST_IDLE;
		endcase

		done = done_q;
		result = result_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= blpf_pkg::ST_SWEEP;
			cnt_q <= '0;
			fill_q <= '0;
			report_q <= 1'b0;
			done_q <= 1'b0;
			pv_s1 <= 1'b0;
			fwd_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			pv_s1 <= (state_q == blpf_pkg::ST_DRAW) && pix.valid && pix_in_panel;
			fwd_valid_q <= we;
			done_q <= 1'b0;
			if (state_q == blpf_pkg::ST_SWEEP) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == LAST_ADDR) begin
					done_q <= report_q;
				end
			end
			if (accept && request.command == blpf_pkg::CMD_FILL) begin
				cnt_q <= '0;
				fill_q <= request.fill_value;
				report_q <= 1'b1;
			end
			if (state_q == blpf_pkg::ST_DRAIN || state_q == blpf_pkg::ST_READ) begin
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		addr_s1 <= pix_addr;
		mask_s1 <= 8'(1) << pix.y[blpf_pkg::PAGE_SHIFT-1:0];
		fwd_addr_q <= waddr;
		fwd_data_q <= wdata;
		if (accept) begin
			color_q <= request.color;
			acc_q <= (request.command == blpf_pkg::CMD_PUT) ? start_in_panel : 1'b1;
			inrange_q <= read_in_range;
		end
		if (state_q == blpf_pkg::ST_READ) begin
			result_q.read_data <= inrange_q ? rdata : 8'd0;
			result_q.accepted <= 1'b1;
		end else if (state_q == blpf_pkg::ST_DRAIN) begin
			result_q.read_data <= 8'd0;
			result_q.accepted <= acc_q;
		end else if (state_q == blpf_pkg::ST_SWEEP) begin
			result_q.read_data <= 8'd0;
			result_q.accepted <= 1'b1;
		end
	end

endmodule

>>> sv/blpf_ram.sv
module blpf_ram #(
	parameter int DEPTH = 512,
	localparam int ADDR_W = $clog2(DEPTH)
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [7:0]        wdata,
	input  logic [ADDR_W-1:0] raddr,
	output logic [7:0]        rdata
);

	logic [7:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

>>> sv/blpf_stepper.sv
module blpf_stepper (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                load,
	input  logic [7:0]          x0,
	input  logic [7:0]          y0,
	input  logic [7:0]          x1,
	input  logic [7:0]          y1,
	output blpf_pkg::pixel_t    pix
);

	logic                           active_q;
	logic [blpf_pkg::COORD_W-1:0]   x_q, y_q, xe_q, ye_q, dx_q, dy_q;
	logic                           sx_q, sy_q;
	logic signed [blpf_pkg::ERR_W-1:0] err_q;

	logic                           at_end;
	logic signed [blpf_pkg::ERR_W-1:0] dxs, dys, err_next;
	logic                           step_x, step_y;
	logic [blpf_pkg::COORD_W-1:0]   ldx, ldy;

	always_comb begin
		at_end = (x_q == xe_q) && (y_q == ye_q);
		dxs = $signed({2'b00, dx_q});
		dys = $signed({2'b00, dy_q});
		step_x = err_q > -dxs;
		step_y = err_q < dys;
		err_next = err_q - (step_x ? dys : '0) + (step_y ? dxs : '0);
		ldx = (x0 < x1) ? (x1 - x0) : (x0 - x1);
		ldy = (y0 < y1) ? (y1 - y0) : (y0 - y1);
		pix.valid = active_q;
		pix.last = at_end;
		pix.x = x_q;
		pix.y = y_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
		end else if (load) begin
			active_q <= 1'b1;
		end else if (active_q && at_end) begin
			active_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			x_q <= x0;
			y_q <= y0;
			xe_q <= x1;
			ye_q <= y1;
			dx_q <= ldx;
			dy_q <= ldy;
			sx_q <= x0 < x1;
			sy_q <= y0 < y1;
			if (ldx > ldy) begin
				err_q <= $signed({3'b000, ldx[7:1]});
			end else begin
				err_q <= -$signed({3'b000, ldy[7:1]});
			end
		end else if (active_q && !at_end) begin
			err_q <= err_next;
			if (step_x) begin
				x_q <= sx_q ? x_q + 8'd1 : x_q - 8'd1;
			end
			if (step_y) begin
				y_q <= sy_q ? y_q + 8'd1 : y_q - 8'd1;
			end
		end
	end

endmodule
